### hdl/bpad_pkg.sv
package bpad_pkg;

   // report kinds
   localparam logic [1:0] CMD_VOLTAGE   = 2'd0;
   localparam logic [1:0] CMD_TEMP      = 2'd1;
   localparam logic [1:0] CMD_OPEN_WIRE = 2'd2;

   localparam int NUM_TIMERS = 15;
   localparam int DUR_BITS   = 13;

   // timer slots
   localparam int T_V_INVALID     = 0;
   localparam int T_V_FAULT_UNDER = 1;
   localparam int T_V_FAULT_OVER  = 2;
   localparam int T_V_WARN_UNDER  = 3;
   localparam int T_V_WARN_OVER   = 4;
   localparam int T_V_INFO_UNDER  = 5;
   localparam int T_V_INFO_OVER   = 6;
   localparam int T_T_INVALID     = 7;
   localparam int T_T_FAULT_OVER  = 8;
   localparam int T_T_FAULT_UNDER = 9;
   localparam int T_T_WARN_OVER   = 10;
   localparam int T_T_WARN_UNDER  = 11;
   localparam int T_T_INFO_OVER   = 12;
   localparam int T_OW_CELL       = 13;
   localparam int T_OW_THERM      = 14;

   typedef logic [DUR_BITS-1:0] dur_array_type [NUM_TIMERS];

   // debounce time of each slot, ms
   localparam dur_array_type DEBOUNCE_MS = '{
      13'd1000, 13'd1000, 13'd1000,
      13'd1000, 13'd1000,
      13'd100,  13'd100,
      13'd3000, 13'd3000, 13'd3000,
      13'd1000, 13'd1000,
      13'd100,
      13'd5000,
      13'd5000
   };

   // voltage limits, mV
   localparam logic signed [15:0] V_FAULT_UNDER = 16'sd2500;
   localparam logic signed [15:0] V_FAULT_OVER  = 16'sd4250;
   localparam logic signed [15:0] V_WARN_UNDER  = 16'sd2700;
   localparam logic signed [15:0] V_WARN_OVER   = 16'sd4220;
   localparam logic signed [15:0] V_INFO_UNDER  = 16'sd2800;
   localparam logic signed [15:0] V_INFO_OVER   = 16'sd4200;

   // temperature limits, 0.1 degC; _CHG applies while charging
   localparam logic signed [15:0] T_FAULT_OVER      = 16'sd550;
   localparam logic signed [15:0] T_FAULT_OVER_CHG  = 16'sd450;
   localparam logic signed [15:0] T_FAULT_UNDER     = -16'sd200;
   localparam logic signed [15:0] T_FAULT_UNDER_CHG = 16'sd0;
   localparam logic signed [15:0] T_WARN_OVER       = 16'sd500;
   localparam logic signed [15:0] T_WARN_OVER_CHG   = 16'sd420;
   localparam logic signed [15:0] T_WARN_UNDER      = -16'sd100;
   localparam logic signed [15:0] T_WARN_UNDER_CHG  = 16'sd50;
   localparam logic signed [15:0] T_INFO_OVER       = 16'sd450;
   localparam logic signed [15:0] T_INFO_OVER_CHG   = 16'sd400;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        now_ms;
      logic               charging;
      logic               stamped;
      logic signed [15:0] min_value;
      logic signed [15:0] max_value;
      logic [63:0]        ok_mask;
      logic [63:0]        therm_ok_mask;
   } req_payload_type;

   typedef struct packed {
      logic       any_fault;
      logic [2:0] fault_bits;
      logic [1:0] warn_bits;
      logic [1:0] info_bits;
   } rsp_payload_type;

   // per-slot condition and whether this report kind drives the slot
   typedef struct packed {
      logic [NUM_TIMERS-1:0] enable;
      logic [NUM_TIMERS-1:0] active;
   } cond_type;

endpackage

### hdl/bpad_if.sv
interface bpad_req_if;
   logic                      valid;
   logic                      ready;
   bpad_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bpad_rsp_if;
   logic                      valid;
   logic                      ready;
   bpad_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/bpad_cond.sv
module bpad_cond #(
   parameter int CHANNELS = 64
) (
   input  bpad_pkg::req_payload_type item,
   output bpad_pkg::cond_type        cond
);

   logic               ok_clear;
   logic               therm_clear;
   logic               st;
   logic               chg;
   logic signed [15:0] mn;
   logic signed [15:0] mx;

   assign ok_clear    = ~&item.ok_mask[CHANNELS-1:0];
   assign therm_clear = ~&item.therm_ok_mask[CHANNELS-1:0];
   assign st  = item.stamped;
   assign chg = item.charging;
   assign mn  = item.min_value;
   assign mx  = item.max_value;

   always_comb begin
      cond.enable = '0;
      cond.active = '0;
      case (item.command)
         bpad_pkg::CMD_VOLTAGE: begin
            cond.enable[bpad_pkg::T_V_INFO_OVER:bpad_pkg::T_V_INVALID] = '1;
         end
         bpad_pkg::CMD_TEMP: begin
            cond.enable[bpad_pkg::T_T_INFO_OVER:bpad_pkg::T_T_INVALID] = '1;
         end
         bpad_pkg::CMD_OPEN_WIRE: begin
            cond.enable[bpad_pkg::T_OW_CELL]  = 1'b1;
            cond.enable[bpad_pkg::T_OW_THERM] = 1'b1;
         end
         default: begin
            cond.enable = '0;
         end
      endcase

      cond.active[bpad_pkg::T_V_INVALID]     = !st || ok_clear;
      cond.active[bpad_pkg::T_V_FAULT_UNDER] = st && (mn < bpad_pkg::V_FAULT_UNDER);
      cond.active[bpad_pkg::T_V_FAULT_OVER]  = st && (mx > bpad_pkg::V_FAULT_OVER);
      cond.active[bpad_pkg::T_V_WARN_UNDER]  = st && (mn < bpad_pkg::V_WARN_UNDER);
      cond.active[bpad_pkg::T_V_WARN_OVER]   = st && (mx > bpad_pkg::V_WARN_OVER);
      cond.active[bpad_pkg::T_V_INFO_UNDER]  = st && (mn < bpad_pkg::V_INFO_UNDER);
      cond.active[bpad_pkg::T_V_INFO_OVER]   = st && (mx > bpad_pkg::V_INFO_OVER);

      cond.active[bpad_pkg::T_T_INVALID]     = !st || ok_clear;
      cond.active[bpad_pkg::T_T_FAULT_OVER]  = st && (mx > (chg ? bpad_pkg::T_FAULT_OVER_CHG
                                                               : bpad_pkg::T_FAULT_OVER));
      cond.active[bpad_pkg::T_T_FAULT_UNDER] = st && (mn < (chg ? bpad_pkg::T_FAULT_UNDER_CHG
                                                               : bpad_pkg::T_FAULT_UNDER));
      cond.active[bpad_pkg::T_T_WARN_OVER]   = st && (mx > (chg ? bpad_pkg::T_WARN_OVER_CHG
                                                               : bpad_pkg::T_WARN_OVER));
      cond.active[bpad_pkg::T_T_WARN_UNDER]  = st && (mn < (chg ? bpad_pkg::T_WARN_UNDER_CHG
                                                               : bpad_pkg::T_WARN_UNDER));
      cond.active[bpad_pkg::T_T_INFO_OVER]   = st && (mx > (chg ? bpad_pkg::T_INFO_OVER_CHG
                                                               : bpad_pkg::T_INFO_OVER));

      cond.active[bpad_pkg::T_OW_CELL]  = st && ok_clear;
      cond.active[bpad_pkg::T_OW_THERM] = st && therm_clear;
   end

endmodule

### hdl/bpad_timers.sv
module bpad_timers #(
   parameter int TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [TIME_BITS-1:0]                  now,
   input  bpad_pkg::cond_type                    cond,
   output logic [bpad_pkg::NUM_TIMERS-1:0]       expired
);

   logic [bpad_pkg::NUM_TIMERS-1:0] running_ff;
   logic [bpad_pkg::NUM_TIMERS-1:0] running_in;
   logic [TIME_BITS-1:0]            start_ff [bpad_pkg::NUM_TIMERS];
   logic [TIME_BITS-1:0]            start_in [bpad_pkg::NUM_TIMERS];
   logic [TIME_BITS-1:0]            elapsed [bpad_pkg::NUM_TIMERS];

   always_comb begin
      for (int i = 0; i < bpad_pkg::NUM_TIMERS; i++) begin
         elapsed[i]    = now - start_ff[i];
         expired[i]    = cond.enable[i] && cond.active[i] && running_ff[i] &&
                         (elapsed[i] >= TIME_BITS'(bpad_pkg::DEBOUNCE_MS[i]));
         running_in[i] = running_ff[i];
         start_in[i]   = start_ff[i];
         if (advance && cond.enable[i]) begin
            if (!cond.active[i]) begin
               // condition dropped: stop and clear
               running_in[i] = 1'b0;
               start_in[i]   = '0;
            end else if (!running_ff[i]) begin
               running_in[i] = 1'b1;
               start_in[i]   = now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         for (int i = 0; i < bpad_pkg::NUM_TIMERS; i++) begin
            start_ff[i] <= '0;
         end
      end else begin
         running_ff <= running_in;
         for (int i = 0; i < bpad_pkg::NUM_TIMERS; i++) begin
            start_ff[i] <= start_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   for (genvar g = 0; g < bpad_pkg::NUM_TIMERS; g++) begin : g_chk
      a_stopped_clear: assert property (@(posedge clock) disable iff (reset)
         !running_ff[g] |-> start_ff[g] == '0)
         else $error("stopped timer holds a start time");
      a_expired_running: assert property (@(posedge clock) disable iff (reset)
         expired[g] |-> running_ff[g] && cond.enable[g])
         else $error("timer expired without running");
   end
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(running_ff))
      else $error("timers changed without a transfer");
`endif

endmodule

### hdl/battery_pack_alert_debouncer.sv
// Battery pack alert debouncer.
// req_ch carries one pack statistics report per transfer (voltage,
// temperature or open-wire kind); rsp_ch returns exactly one alert word per
// report, in order. Both channels use valid/ready; a transfer happens on a
// rising clock edge with valid and ready high.
// A report taken from req_ch sits in the input register, is compared
// against the limits and run through its debounce timers, and its alert word
// moves to the output register, which drives rsp_ch. Throughput: one report
// per cycle unless rsp_ch stalls; the 15 debounce timers are separate
// registers updated in parallel as a report leaves the input register.
// When rsp_ch stalls, the output register holds its word, the input register
// can still take one more report, and req_ch.ready drops once both are full.
// Timer time is the low TIME_BITS bits of now_ms and wraps modulo 2^TIME_BITS.
// Synchronous reset stops all timers and empties both registers.
module battery_pack_alert_debouncer #(
   parameter int CHANNELS  = 64,
   parameter int TIME_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   bpad_req_if.sink          req_ch,
   bpad_rsp_if.source        rsp_ch
);

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   bpad_pkg::req_payload_type s1_data_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   bpad_pkg::rsp_payload_type rsp_data_ff;
   bpad_pkg::rsp_payload_type rsp_data_in;

   logic                            s1_ready;
   logic                            s2_ready;
   logic                            advance;
   bpad_pkg::cond_type              cond;
   logic [bpad_pkg::NUM_TIMERS-1:0] expired;

   // output register frees up when empty or being taken
   assign s2_ready = !rsp_valid_ff || rsp_ch.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign advance  = s1_valid_ff && s2_ready;

   assign req_ch.ready = s1_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   bpad_cond #(
      .CHANNELS (CHANNELS)
   ) u_cond (
      .item (s1_data_ff),
      .cond (cond)
   );

   bpad_timers #(
      .TIME_BITS (TIME_BITS)
   ) u_timers (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .now     (s1_data_ff.now_ms[TIME_BITS-1:0]),
      .cond    (cond),
      .expired (expired)
   );

   // map expired timers onto the alert word of the reported kind
   always_comb begin
      rsp_data_in = '0;
      case (s1_data_ff.command)
         bpad_pkg::CMD_VOLTAGE: begin
            rsp_data_in.fault_bits = {expired[bpad_pkg::T_V_FAULT_OVER],
                                      expired[bpad_pkg::T_V_FAULT_UNDER],
                                      expired[bpad_pkg::T_V_INVALID]};
            rsp_data_in.warn_bits  = {expired[bpad_pkg::T_V_WARN_OVER],
                                      expired[bpad_pkg::T_V_WARN_UNDER]};
            rsp_data_in.info_bits  = {expired[bpad_pkg::T_V_INFO_OVER],
                                      expired[bpad_pkg::T_V_INFO_UNDER]};
         end
         bpad_pkg::CMD_TEMP: begin
            rsp_data_in.fault_bits = {expired[bpad_pkg::T_T_FAULT_OVER],
                                      expired[bpad_pkg::T_T_FAULT_UNDER],
                                      expired[bpad_pkg::T_T_INVALID]};
            rsp_data_in.warn_bits  = {expired[bpad_pkg::T_T_WARN_OVER],
                                      expired[bpad_pkg::T_T_WARN_UNDER]};
            rsp_data_in.info_bits  = {expired[bpad_pkg::T_T_INFO_OVER], 1'b0};
         end
         bpad_pkg::CMD_OPEN_WIRE: begin
            rsp_data_in.fault_bits = {2'b00, expired[bpad_pkg::T_OW_CELL]};
            rsp_data_in.info_bits  = {1'b0, expired[bpad_pkg::T_OW_THERM]};
         end
         default: begin
            // unused kind: all-zero word, timers untouched
            rsp_data_in = '0;
         end
      endcase
      rsp_data_in.any_fault = |rsp_data_in.fault_bits;
   end

   // hold the input register unless it drains or is empty
   assign s1_valid_in  = s1_ready ? req_ch.valid : s1_valid_ff;
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && s1_ready) begin
         s1_data_ff <= req_ch.data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_active_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.any_fault == (|rsp_data_ff.fault_bits))
      else $error("any_fault disagrees with fault_bits");
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      advance && s1_data_ff.command != bpad_pkg::CMD_VOLTAGE &&
      s1_data_ff.command != bpad_pkg::CMD_TEMP &&
      s1_data_ff.command != bpad_pkg::CMD_OPEN_WIRE |=> rsp_data_ff == '0)
      else $error("unused report kind produced alerts");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("input stalled with an empty output register");
`endif

endmodule

### dv/bpad_alert_checker.sv
module bpad_alert_checker #(
   parameter int CHANNELS  = 64,
   parameter int TIME_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   bpad_req_if  req_ch,
   bpad_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import bpad_pkg::*;

   localparam bit [63:0] CHAN_MASK = {64{1'b1}} >> (64 - CHANNELS);
   localparam bit [31:0] TIME_MASK = {32{1'b1}} >> (32 - TIME_BITS);

   bit              hold_on    [NUM_TIMERS];
   bit [31:0]       hold_since [NUM_TIMERS];
   rsp_payload_type alert_queue [$];
   int              miss_total;

   function automatic int hold_ms(int slot);
      case (slot)
         T_V_INFO_UNDER, T_V_INFO_OVER, T_T_INFO_OVER:   return 100;
         T_T_INVALID, T_T_FAULT_OVER, T_T_FAULT_UNDER:   return 3000;
         T_OW_CELL, T_OW_THERM:                          return 5000;
         default:                                        return 1000;
      endcase
   endfunction

   function automatic bit lacks_channel(logic [63:0] bits);
      return (bits & CHAN_MASK) != CHAN_MASK;
   endfunction

   // Advance one debounce timer and report whether it has expired.
   function automatic bit debounce_step(int slot, bit cond, bit [31:0] now);
      if (!cond) begin
         hold_on[slot]    = 1'b0;
         hold_since[slot] = '0;
         return 1'b0;
      end
      if (!hold_on[slot]) begin
         hold_on[slot]    = 1'b1;
         hold_since[slot] = now;
      end
      return ((now - hold_since[slot]) & TIME_MASK) >= hold_ms(slot);
   endfunction

   function automatic rsp_payload_type predict_alert(req_payload_type r);
      rsp_payload_type    a;
      bit [31:0]          now;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      bit                 fresh;
      bit                 chg;
      bit [2:0]           f;
      bit [1:0]           w;
      bit [1:0]           n;
      a     = '0;
      f     = '0;
      w     = '0;
      n     = '0;
      now   = r.now_ms & TIME_MASK;
      lo    = r.min_value;
      hi    = r.max_value;
      fresh = r.stamped;
      chg   = r.charging;
      case (r.command)
         CMD_VOLTAGE: begin
            f[0] = debounce_step(T_V_INVALID, !fresh || lacks_channel(r.ok_mask), now);
            f[1] = debounce_step(T_V_FAULT_UNDER, fresh && lo < V_FAULT_UNDER, now);
            f[2] = debounce_step(T_V_FAULT_OVER, fresh && hi > V_FAULT_OVER, now);
            w[0] = debounce_step(T_V_WARN_UNDER, fresh && lo < V_WARN_UNDER, now);
            w[1] = debounce_step(T_V_WARN_OVER, fresh && hi > V_WARN_OVER, now);
            n[0] = debounce_step(T_V_INFO_UNDER, fresh && lo < V_INFO_UNDER, now);
            n[1] = debounce_step(T_V_INFO_OVER, fresh && hi > V_INFO_OVER, now);
         end
         CMD_TEMP: begin
            f[0] = debounce_step(T_T_INVALID, !fresh || lacks_channel(r.ok_mask), now);
            f[2] = debounce_step(T_T_FAULT_OVER,
                      fresh && hi > (chg ? T_FAULT_OVER_CHG : T_FAULT_OVER), now);
            f[1] = debounce_step(T_T_FAULT_UNDER,
                      fresh && lo < (chg ? T_FAULT_UNDER_CHG : T_FAULT_UNDER), now);
            w[1] = debounce_step(T_T_WARN_OVER,
                      fresh && hi > (chg ? T_WARN_OVER_CHG : T_WARN_OVER), now);
            w[0] = debounce_step(T_T_WARN_UNDER,
                      fresh && lo < (chg ? T_WARN_UNDER_CHG : T_WARN_UNDER), now);
            n[1] = debounce_step(T_T_INFO_OVER,
                      fresh && hi > (chg ? T_INFO_OVER_CHG : T_INFO_OVER), now);
         end
         CMD_OPEN_WIRE: begin
            f[0] = debounce_step(T_OW_CELL, fresh && lacks_channel(r.ok_mask), now);
            n[0] = debounce_step(T_OW_THERM, fresh && lacks_channel(r.therm_ok_mask), now);
         end
         default: ;
      endcase
      a.any_fault  = |f;
      a.fault_bits = f;
      a.warn_bits  = w;
      a.info_bits  = n;
      return a;
   endfunction

   function automatic int check_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            hold_on[i]    = 1'b0;
            hold_since[i] = '0;
         end
         alert_queue.delete();
         miss_total = 0;
      end else begin
         // retire the result first so a transfer into an empty store is caught
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (alert_queue.size() == 0) begin
               $display("%0t: unexpected alert, expected none, actual %h", $time, got);
               miss_total++;
            end else begin
               want = alert_queue.pop_front();
               miss_total += check_field("any_fault", 4'(want.any_fault),
                                         4'(got.any_fault));
               miss_total += check_field("fault_bits", 4'(want.fault_bits),
                                         4'(got.fault_bits));
               miss_total += check_field("warn_bits", 4'(want.warn_bits),
                                         4'(got.warn_bits));
               miss_total += check_field("info_bits", 4'(want.info_bits),
                                         4'(got.info_bits));
            end
         end
         if (req_ch.valid && req_ch.ready)
            alert_queue.push_back(predict_alert(req_ch.data));
      end
      fail_count <= miss_total;
      pending    <= alert_queue.size();
   end

endmodule

### dv/battery_pack_alert_debouncer_tb.sv
module battery_pack_alert_debouncer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpad_pkg::*;

   // report kind the block does not decode
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [63:0] ALL_OK     = {64{1'b1}};
   localparam int RANDOM_REPORTS      = 1750;
   localparam int STALL_LIMIT         = 5000;
   localparam int DRAIN_CYCLES        = 8;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   bpad_req_if req_ch ();
   bpad_rsp_if rsp_ch ();

   battery_pack_alert_debouncer #(
      .CHANNELS  (64),
      .TIME_BITS (32)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bpad_alert_checker #(
      .CHANNELS  (64),
      .TIME_BITS (32)
   ) u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Stimulus state that persists across reports: the pack clock, the charge
   // state and the current cell levels. Levels only move now and then, so a
   // condition tends to hold long enough for its debounce timer to expire.
   bit [31:0]          t_now;
   bit                 charge_on;
   logic signed [15:0] v_lo, v_hi;
   logic signed [15:0] t_lo, t_hi;
   logic [63:0]        cell_ok, therm_ok;
   bit                 no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: count cycles in which neither channel moves a transfer.
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: stall a random number of cycles before each transfer,
   // except during stretches where both sides run flat out.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   function automatic req_payload_type make_report(
      logic [1:0] cmd, logic [31:0] now, bit chg, bit st,
      logic signed [15:0] lo, logic signed [15:0] hi,
      logic [63:0] ok, logic [63:0] tok);
      req_payload_type p;
      p.command       = cmd;
      p.now_ms        = now;
      p.charging      = chg;
      p.stamped       = st;
      p.min_value     = lo;
      p.max_value     = hi;
      p.ok_mask       = ok;
      p.therm_ok_mask = tok;
      return p;
   endfunction

   // Hold off a random gap, then present the report and hold it until the
   // transfer. Leave valid high afterwards so back-to-back reports never
   // see valid dropped and raised in the same step.
   task automatic send_report(input req_payload_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted alert has come back.
   task automatic drain_alerts();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_volt();
      int pts [6] = '{2500, 2700, 2800, 4200, 4220, 4250};
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      if (r < 3)
         return 16'($urandom_range(2900, 4100));
      return 16'(pts[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2);
   endfunction

   function automatic logic signed [15:0] pick_temp();
      int pts [9] = '{-200, -100, 0, 50, 400, 420, 450, 500, 550};
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      if (r < 3)
         return 16'($urandom_range(100, 350));
      return 16'(pts[$urandom_range(0, 8)] + $urandom_range(0, 4) - 2);
   endfunction

   function automatic logic [63:0] pick_mask();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return ALL_OK;
      if (r < 90) return ALL_OK ^ (64'd1 << $urandom_range(0, 63));
      if (r < 95) return {$urandom, $urandom};
      return '0;
   endfunction

   // Build one random report. Most are well formed: time moves forward and
   // levels persist. One in ten is noise with every field at random.
   task automatic random_report(output req_payload_type p);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)      t_now += $urandom_range(0, 150);
      else if (r < 85) t_now += $urandom_range(150, 1200);
      else if (r < 96) t_now += $urandom_range(1200, 6000);
      else             t_now += $urandom;
      if ($urandom_range(0, 29) == 0) charge_on = ~charge_on;
      if ($urandom_range(0, 5) == 0)  v_lo = pick_volt();
      if ($urandom_range(0, 5) == 0)  v_hi = pick_volt();
      if ($urandom_range(0, 5) == 0)  t_lo = pick_temp();
      if ($urandom_range(0, 5) == 0)  t_hi = pick_temp();
      if ($urandom_range(0, 4) == 0)  cell_ok = pick_mask();
      if ($urandom_range(0, 4) == 0)  therm_ok = pick_mask();

      if ($urandom_range(0, 9) == 0) begin
         p = make_report(2'($urandom), $urandom, 1'($urandom), 1'($urandom),
                         16'($urandom), 16'($urandom),
                         {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5)
            p = make_report(CMD_UNUSED, t_now, charge_on, 1'b1, v_lo, v_hi, cell_ok,
                            therm_ok);
         else if (r < 45)
            p = make_report(CMD_VOLTAGE, t_now, charge_on, $urandom_range(0, 24) != 0,
                            v_lo, v_hi, cell_ok, therm_ok);
         else if (r < 85)
            p = make_report(CMD_TEMP, t_now, charge_on, $urandom_range(0, 24) != 0,
                            t_lo, t_hi, cell_ok, therm_ok);
         else
            p = make_report(CMD_OPEN_WIRE, t_now, charge_on, $urandom_range(0, 24) != 0,
                            t_lo, t_hi, cell_ok, therm_ok);
      end
   endtask

   initial begin
      req_payload_type p;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      reset        <= 1'b1;
      no_idle      = 1'b0;
      t_now        = '0;
      charge_on    = 1'b0;
      v_lo         = 16'sd3500;
      v_hi         = 16'sd4000;
      t_lo         = 16'sd200;
      t_hi         = 16'sd300;
      cell_ok      = ALL_OK;
      therm_ok     = ALL_OK;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Voltage: quiet pack, then both extremes held until info, then
      // fault and warning timers expire.
      send_report(make_report(CMD_VOLTAGE, 0, 0, 1, 3500, 4000, ALL_OK, ALL_OK));
      send_report(make_report(CMD_VOLTAGE, 0, 0, 1, -32768, 32767, ALL_OK, ALL_OK));
      send_report(make_report(CMD_VOLTAGE, 100, 0, 1, -32768, 32767, ALL_OK, ALL_OK));
      send_report(make_report(CMD_VOLTAGE, 1000, 0, 1, -32768, 32767, ALL_OK, ALL_OK));
      // Stale measurement: invalid starts, every level timer clears.
      send_report(make_report(CMD_VOLTAGE, 1001, 0, 0, -32768, 32767, ALL_OK, ALL_OK));
      send_report(make_report(CMD_VOLTAGE, 2001, 0, 0, -32768, 32767, ALL_OK, ALL_OK));
      // Exact fault limits with one missing channel keep invalid asserted.
      send_report(make_report(CMD_VOLTAGE, 2002, 0, 1, 2500, 4250,
                              ALL_OK ^ (64'd1 << 63), ALL_OK));

      // Temperature: nominal limits exceeded, then the charging limits
      // take over, then exact limits in both charge states.
      send_report(make_report(CMD_TEMP, 3000, 0, 1, -201, 551, ALL_OK, ALL_OK));
      send_report(make_report(CMD_TEMP, 6000, 1, 1, -1, 451, ALL_OK, ALL_OK));
      send_report(make_report(CMD_TEMP, 6001, 1, 1, 0, 450, ALL_OK, ALL_OK));
      send_report(make_report(CMD_TEMP, 6002, 0, 1, -200, 550, ALL_OK, ALL_OK));
      send_report(make_report(CMD_TEMP, 9002, 0, 1, 300, 300, '0, ALL_OK));
      send_report(make_report(CMD_TEMP, 12002, 0, 1, 300, 300, '0, ALL_OK));

      // Open wire on every cell and thermistor, held for its debounce time.
      send_report(make_report(CMD_OPEN_WIRE, 13000, 0, 1, 0, 0, '0, '0));
      send_report(make_report(CMD_OPEN_WIRE, 18000, 0, 1, 0, 0, '0, '0));
      // Unused kind must answer with zeros and leave timers alone.
      send_report(make_report(CMD_UNUSED, 18000, 1, 1, -32768, 32767, '0, '0));
      send_report(make_report(CMD_OPEN_WIRE, 18001, 0, 1, 0, 0, ALL_OK, 64'h1));
      send_report(make_report(CMD_OPEN_WIRE, 18002, 0, 0, 0, 0, '0, '0));

      // Time wrap: a hold across the counter wrap still expires, while a
      // hold of one full wrap plus a few ms reads as not expired.
      send_report(make_report(CMD_VOLTAGE, 32'hFFFF_FF00, 0, 1, 2000, 4000, ALL_OK, ALL_OK));
      send_report(make_report(CMD_VOLTAGE, 32'h0000_0300, 0, 1, 2000, 4000, ALL_OK, ALL_OK));
      send_report(make_report(CMD_VOLTAGE, 32'h7FFF_FF00, 0, 1, 2000, 4000, ALL_OK, ALL_OK));
      send_report(make_report(CMD_VOLTAGE, 32'hFFFF_FF05, 0, 1, 2000, 4000, ALL_OK, ALL_OK));

      t_now = 32'hFFFF_FF05;
      for (int i = 0; i < RANDOM_REPORTS; i++) begin
         // switch idling off for roughly one block in four
         if (i % 125 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         // pause the sender once until the block has answered everything
         if (i == RANDOM_REPORTS / 2)
            drain_alerts();
         random_report(p);
         send_report(p);
      end

      drain_alerts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
